// ===== rtl/blc_pkg.sv =====
package blc_pkg;

  localparam int SAMPLES_DEF     = 8;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int VALUE_BITS = 11;
  localparam int LEVEL_BITS = 3;
  localparam int COUNT_BITS = 4;
  localparam int INDEX_BITS = 3;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = 11'd2047;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_FULL     = 3'd0,
    REG_HIGH     = 3'd1,
    REG_MID      = 3'd2,
    REG_LOW      = 3'd3,
    REG_CRITICAL = 3'd4,
    REG_CONFIRM  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] full;
    logic [VALUE_BITS-1:0] high;
    logic [VALUE_BITS-1:0] mid;
    logic [VALUE_BITS-1:0] low;
    logic [VALUE_BITS-1:0] critical;
    logic [COUNT_BITS-1:0] confirm;
  } cfg_t;

  localparam logic [VALUE_BITS-1:0] FULL_RST     = 11'd840;
  localparam logic [VALUE_BITS-1:0] HIGH_RST     = 11'd810;
  localparam logic [VALUE_BITS-1:0] MID_RST      = 11'd780;
  localparam logic [VALUE_BITS-1:0] LOW_RST      = 11'd750;
  localparam logic [VALUE_BITS-1:0] CRITICAL_RST = 11'd730;
  localparam logic [COUNT_BITS-1:0] CONFIRM_RST  = 4'd4;

  localparam logic [LEVEL_BITS-1:0] LEVEL_NONE = 3'd0;
  localparam logic [LEVEL_BITS-1:0] LEVEL_1    = 3'd1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_2    = 3'd2;
  localparam logic [LEVEL_BITS-1:0] LEVEL_3    = 3'd3;
  localparam logic [LEVEL_BITS-1:0] LEVEL_4    = 3'd4;
  localparam logic [LEVEL_BITS-1:0] LEVEL_5    = 3'd5;
  localparam logic [LEVEL_BITS-1:0] LEVEL_6    = 3'd6;

  localparam int OFS_BITS = 5;
  localparam logic [2:0] DRIVE_PWM = 3'd1;
  localparam logic [2:0] DRIVE_MID = 3'd2;
  localparam logic [2:0] DRIVE_LOW = 3'd4;
  localparam logic [1:0] STEP_ONE  = 2'd1;
  localparam logic [1:0] STEP_TWO  = 2'd2;

  localparam logic [OFS_BITS-1:0] OFS_NONE       = 5'h00;
  localparam logic [OFS_BITS-1:0] OFS_STEP_ONE   = 5'h0C;
  localparam logic [OFS_BITS-1:0] OFS_STEP_TWO   = 5'h14;
  localparam logic [OFS_BITS-1:0] OFS_STEP_OTHER = 5'h1C;
  localparam logic [OFS_BITS-1:0] OFS_DRIVE_MID  = 5'h10;
  localparam logic [OFS_BITS-1:0] OFS_DRIVE_LOW  = 5'h08;

  localparam int SUB_BITS = 6;
  localparam logic [SUB_BITS-1:0] SUB_LOW  = 6'd32;
  localparam logic [SUB_BITS-1:0] SUB_MID  = 6'd26;
  localparam logic [SUB_BITS-1:0] SUB_HIGH = 6'd20;

  function automatic logic [OFS_BITS-1:0] load_offset(input logic [2:0] drive,
                                                      input logic [1:0] step);
    logic [OFS_BITS-1:0] ofs;
    ofs = OFS_NONE;
    if (drive == DRIVE_PWM) begin
      if (step == STEP_ONE) begin
        ofs = OFS_STEP_ONE;
      end else if (step == STEP_TWO) begin
        ofs = OFS_STEP_TWO;
      end else begin
        ofs = OFS_STEP_OTHER;
      end
    end else if (drive == DRIVE_MID) begin
      ofs = OFS_DRIVE_MID;
    end else if (drive == DRIVE_LOW) begin
      ofs = OFS_DRIVE_LOW;
    end
    return ofs;
  endfunction

  function automatic logic [SUB_BITS-1:0] charge_sub(input logic [LEVEL_BITS-1:0] level);
    logic [SUB_BITS-1:0] sub;
    if (level < LEVEL_3) begin
      sub = SUB_LOW;
    end else if (level < LEVEL_5) begin
      sub = SUB_MID;
    end else begin
      sub = SUB_HIGH;
    end
    return sub;
  endfunction

  function automatic logic [LEVEL_BITS-1:0] map_level(input logic [VALUE_BITS-1:0] v,
                                                      input cfg_t cfg);
    logic [LEVEL_BITS-1:0] lvl;
    if (v > cfg.full) begin
      lvl = LEVEL_6;
    end else if (v > cfg.high) begin
      lvl = LEVEL_5;
    end else if (v > cfg.mid) begin
      lvl = LEVEL_4;
    end else if (v > cfg.low) begin
      lvl = LEVEL_3;
    end else if (v > cfg.critical) begin
      lvl = LEVEL_2;
    end else begin
      lvl = LEVEL_1;
    end
    return lvl;
  endfunction

endpackage

// ===== rtl/blc_split.sv =====
module blc_split #(
  parameter int SAMPLES     = blc_pkg::SAMPLES_DEF,
  parameter int SAMPLE_BITS = blc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [SAMPLE_BITS-1:0]           in_sample,
  input  logic [2:0]                       in_drive,
  input  logic [1:0]                       in_step,
  input  logic                             in_charging,
  output logic                             q_valid,
  input  logic                             q_ready,
  output logic [SAMPLE_BITS-1:0]           q_quot,
  output logic [$clog2(SAMPLES)-1:0]       q_rem,
  output logic [2:0]                       q_drive,
  output logic [1:0]                       q_step,
  output logic                             q_charging
);

  localparam int RW = $clog2(SAMPLES);
  localparam int SH = SAMPLE_BITS + RW;
  localparam int MW = SAMPLE_BITS + 2;
  localparam int PW = SH + SAMPLE_BITS;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + longint'(SAMPLES) - 64'd1) / longint'(SAMPLES);
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);
  localparam logic [SAMPLE_BITS-1:0] DIV_C = SAMPLE_BITS'(SAMPLES);

  logic                   valid;
  logic [SAMPLE_BITS-1:0] sample;
  logic [2:0]             drive;
  logic [1:0]             step;
  logic                   charging;

  logic                   stage_ready;
  logic [PW-1:0]          prod;
  logic [SAMPLE_BITS-1:0] quot;
  logic [SAMPLE_BITS-1:0] back;
  logic [SAMPLE_BITS-1:0] rem_full;

  assign stage_ready = !q_valid || q_ready;
  assign in_ready    = !valid || stage_ready;

  // quotient by reciprocal, exact for every sample value
  assign prod     = PW'(sample) * PW'(RECIP_C);
  assign quot     = prod[SH +: SAMPLE_BITS];
  assign back     = SAMPLE_BITS'(quot * DIV_C);
  assign rem_full = sample - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample   <= in_sample;
      drive    <= in_drive;
      step     <= in_step;
      charging <= in_charging;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (stage_ready) begin
      q_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && stage_ready) begin
      q_quot     <= quot;
      q_rem      <= rem_full[RW-1:0];
      q_drive    <= drive;
      q_step     <= step;
      q_charging <= charging;
    end
  end

endmodule

// ===== rtl/blc_accum.sv =====
module blc_accum #(
  parameter int SAMPLES     = blc_pkg::SAMPLES_DEF,
  parameter int SAMPLE_BITS = blc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  logic [SAMPLE_BITS-1:0]     q_quot,
  input  logic [$clog2(SAMPLES)-1:0] q_rem,
  input  logic [2:0]                 q_drive,
  input  logic [1:0]                 q_step,
  input  logic                       q_charging,
  output logic                       b_valid,
  input  logic                       b_ready,
  output logic [SAMPLE_BITS-1:0]     b_avg,
  output logic [2:0]                 b_drive,
  output logic [1:0]                 b_step,
  output logic                       b_charging
);

  localparam int RW = $clog2(SAMPLES);
  localparam logic [RW-1:0] LAST_C = RW'(SAMPLES - 1);
  localparam logic [RW:0]   DIV_C  = (RW + 1)'(SAMPLES);

  logic [RW-1:0]          sample_count;
  logic [SAMPLE_BITS-1:0] quot_acc;
  logic [RW-1:0]          rem_acc;

  logic                   last;
  logic                   stage_ready;
  logic                   take;
  logic [RW:0]            rem_sum;
  logic                   carry;
  logic [RW:0]            rem_wrap;
  logic [SAMPLE_BITS-1:0] quot_sum;

  assign last        = sample_count == LAST_C;
  assign stage_ready = !b_valid || b_ready;
  assign q_ready     = !last || stage_ready;
  assign take        = q_valid && q_ready;

  // remainders stay below the block size, one correction step is enough
  assign rem_sum  = {1'b0, rem_acc} + {1'b0, q_rem};
  assign carry    = rem_sum >= DIV_C;
  assign rem_wrap = carry ? rem_sum - DIV_C : rem_sum;
  assign quot_sum = quot_acc + q_quot + SAMPLE_BITS'(carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      quot_acc     <= '0;
      rem_acc      <= '0;
    end else if (take) begin
      if (last) begin
        sample_count <= '0;
        quot_acc     <= '0;
        rem_acc      <= '0;
      end else begin
        sample_count <= sample_count + RW'(1);
        quot_acc     <= quot_sum;
        rem_acc      <= rem_wrap[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (stage_ready) begin
      b_valid <= take && last;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      b_avg      <= quot_sum;
      b_drive    <= q_drive;
      b_step     <= q_step;
      b_charging <= q_charging;
    end
  end

endmodule

// ===== rtl/blc_grade.sv =====
module blc_grade #(
  parameter int SAMPLE_BITS = blc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  blc_pkg::cfg_t                       cfg,
  input  logic                                b_valid,
  output logic                                b_ready,
  input  logic [SAMPLE_BITS-1:0]              b_avg,
  input  logic [2:0]                          b_drive,
  input  logic [1:0]                          b_step,
  input  logic                                b_charging,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [blc_pkg::LEVEL_BITS-1:0]      battery_level,
  output logic [blc_pkg::VALUE_BITS-1:0]      compensated_value,
  output logic [blc_pkg::LEVEL_BITS-1:0]      candidate_level
);

  localparam int EW = (SAMPLE_BITS + 1 > blc_pkg::VALUE_BITS + 1) ?
                      SAMPLE_BITS + 1 : blc_pkg::VALUE_BITS + 1;

  logic [blc_pkg::LEVEL_BITS-1:0] level_now;
  logic [blc_pkg::COUNT_BITS-1:0] mismatch_count;

  logic [blc_pkg::LEVEL_BITS-1:0] level_next;
  logic [blc_pkg::COUNT_BITS-1:0] mismatch_next;

  logic                           take;
  logic [EW-1:0]                  raw;
  logic [EW-1:0]                  sub;
  logic [EW-1:0]                  charged;
  logic [blc_pkg::VALUE_BITS-1:0] comp;
  logic [blc_pkg::LEVEL_BITS-1:0] cand;
  logic [blc_pkg::COUNT_BITS:0]   mis_inc;

  assign b_ready = !out_valid || out_ready;
  assign take    = b_valid && b_ready;

  always_comb begin
    raw = EW'(b_avg) + EW'(blc_pkg::load_offset(b_drive, b_step));
    sub = EW'(blc_pkg::charge_sub(level_now));
    if (b_charging) begin
      charged = (raw > sub) ? raw - sub : '0;
    end else begin
      charged = raw;
    end
    if (charged > EW'(blc_pkg::VALUE_MAX)) begin
      comp = blc_pkg::VALUE_MAX;
    end else begin
      comp = charged[blc_pkg::VALUE_BITS-1:0];
    end
    cand = blc_pkg::map_level(comp, cfg);
  end

  always_comb begin
    mis_inc       = {1'b0, mismatch_count} + (blc_pkg::COUNT_BITS + 1)'(1);
    level_next    = level_now;
    mismatch_next = '0;
    if (cand != level_now) begin
      if (mis_inc > {1'b0, cfg.confirm}) begin
        level_next = cand;
      end else begin
        mismatch_next = mis_inc[blc_pkg::COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_now      <= blc_pkg::LEVEL_NONE;
      mismatch_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        level_now      <= level_next;
        mismatch_count <= mismatch_next;
      end
      if (b_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      battery_level     <= level_next;
      compensated_value <= comp;
      candidate_level   <= cand;
    end
  end

endmodule

// ===== rtl/battery_level_estimator.sv =====
// Battery level estimator: takes one ADC conversion per request on the in channel and,
// after every SAMPLES conversions, gives one result with the block average after load
// and charging compensation, the level it maps to, and the confirmed battery level.
// A conversion can be taken every clock cycle unless the pipeline stalls. The input
// register, the reciprocal divide stage, the block accumulator and the result register
// form the pipeline; it stalls only when the result register holds a result that is
// not taken while every stage is full. Load offset, pwm step and charging flag come
// from the last conversion of a block. Thresholds and the confirm limit are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no block is
// in flight, which the block itself does not enforce.
module battery_level_estimator #(
  parameter int SAMPLES     = blc_pkg::SAMPLES_DEF,
  parameter int SAMPLE_BITS = blc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [blc_pkg::INDEX_BITS-1:0] cfg_index,
  input  logic [blc_pkg::VALUE_BITS-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SAMPLE_BITS-1:0]         adc_sample,
  input  logic [2:0]                     drive_level,
  input  logic [1:0]                     pwm_step,
  input  logic                           charging,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [blc_pkg::LEVEL_BITS-1:0] battery_level,
  output logic [blc_pkg::VALUE_BITS-1:0] compensated_value,
  output logic [blc_pkg::LEVEL_BITS-1:0] candidate_level
);

  localparam int RW = $clog2(SAMPLES);

  blc_pkg::cfg_t cfg;

  logic                   q_valid;
  logic                   q_ready;
  logic [SAMPLE_BITS-1:0] q_quot;
  logic [RW-1:0]          q_rem;
  logic [2:0]             q_drive;
  logic [1:0]             q_step;
  logic                   q_charging;

  logic                   b_valid;
  logic                   b_ready;
  logic [SAMPLE_BITS-1:0] b_avg;
  logic [2:0]             b_drive;
  logic [1:0]             b_step;
  logic                   b_charging;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full     <= blc_pkg::FULL_RST;
      cfg.high     <= blc_pkg::HIGH_RST;
      cfg.mid      <= blc_pkg::MID_RST;
      cfg.low      <= blc_pkg::LOW_RST;
      cfg.critical <= blc_pkg::CRITICAL_RST;
      cfg.confirm  <= blc_pkg::CONFIRM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        blc_pkg::REG_FULL:     cfg.full     <= cfg_data;
        blc_pkg::REG_HIGH:     cfg.high     <= cfg_data;
        blc_pkg::REG_MID:      cfg.mid      <= cfg_data;
        blc_pkg::REG_LOW:      cfg.low      <= cfg_data;
        blc_pkg::REG_CRITICAL: cfg.critical <= cfg_data;
        blc_pkg::REG_CONFIRM:  cfg.confirm  <= cfg_data[blc_pkg::COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  blc_split #(
    .SAMPLES     (SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_split (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (adc_sample),
    .in_drive    (drive_level),
    .in_step     (pwm_step),
    .in_charging (charging),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_quot      (q_quot),
    .q_rem       (q_rem),
    .q_drive     (q_drive),
    .q_step      (q_step),
    .q_charging  (q_charging)
  );

  blc_accum #(
    .SAMPLES     (SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_quot     (q_quot),
    .q_rem      (q_rem),
    .q_drive    (q_drive),
    .q_step     (q_step),
    .q_charging (q_charging),
    .b_valid    (b_valid),
    .b_ready    (b_ready),
    .b_avg      (b_avg),
    .b_drive    (b_drive),
    .b_step     (b_step),
    .b_charging (b_charging)
  );

  blc_grade #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_grade (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .b_valid           (b_valid),
    .b_ready           (b_ready),
    .b_avg             (b_avg),
    .b_drive           (b_drive),
    .b_step            (b_step),
    .b_charging        (b_charging),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .battery_level     (battery_level),
    .compensated_value (compensated_value),
    .candidate_level   (candidate_level)
  );

`ifndef ASSERT_OFF
  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while result path is free");

  a_candidate_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (candidate_level >= blc_pkg::LEVEL_1 && candidate_level <= blc_pkg::LEVEL_6))
    else $error("candidate level out of range");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (battery_level <= blc_pkg::LEVEL_6))
    else $error("battery level out of range");

  a_no_result_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");
`endif

endmodule
